// ===== rtl/smdr_pkg.sv =====
// Package for the signed multiply/divide/remainder unit.
// Holds the operation codes, the queued operation record and the sequencer states.
package smdr_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned HalfW  = 32;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned CntW   = 6;

  typedef enum logic [1:0] {
    MODE_MUL = 2'd0,
    MODE_DIV = 2'd1,
    MODE_REM = 2'd2,
    MODE_NOP = 2'd3
  } mode_t;

  // Classified operation: zero-result cases are settled in the front.
  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_REM  = 2'd2,
    OP_ZERO = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic             wide;
    logic             dbz;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MUL  = 2'd1,
    ST_DIV  = 2'd2,
    ST_FIN  = 2'd3
  } state_t;

endpackage

// ===== rtl/smdr_front.sv =====
// Front stage: registers incoming words, sign-extends 32-bit operands and classifies.
// Depends on smdr_pkg.
module smdr_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_mode,
  input  logic                     in_wide,
  input  logic [63:0]              in_operand_a,
  input  logic [63:0]              in_operand_b,
  output logic                     op_valid,
  input  logic                     op_ready,
  output smdr_pkg::op_t            op
);
  import smdr_pkg::*;

  logic             valid_r;
  op_t              op_r;
  op_t              op_nxt;
  logic [DataW-1:0] a_ext;
  logic [DataW-1:0] b_ext;
  mode_t            mode;

  assign in_ready = !valid_r || op_ready;
  assign op_valid = valid_r;
  assign op       = op_r;
  assign mode     = mode_t'(in_mode);

  always_comb begin
    a_ext = in_wide ? in_operand_a : {{HalfW{in_operand_a[HalfW-1]}}, in_operand_a[HalfW-1:0]};
    b_ext = in_wide ? in_operand_b : {{HalfW{in_operand_b[HalfW-1]}}, in_operand_b[HalfW-1:0]};
    op_nxt.wide = in_wide;
    op_nxt.a    = a_ext;
    op_nxt.b    = b_ext;
    op_nxt.dbz  = 1'b0;
    unique case (mode)
      MODE_MUL: op_nxt.kind = OP_MUL;
      MODE_DIV, MODE_REM: begin
        if (b_ext == '0) begin
          op_nxt.kind = OP_ZERO;
          op_nxt.dbz  = 1'b1;
        end else begin
          op_nxt.kind = (mode == MODE_DIV) ? OP_DIV : OP_REM;
        end
      end
      default: op_nxt.kind = OP_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      op_r <= op_nxt;
    end
  end

endmodule

// ===== rtl/smdr_queue.sv =====
// Short queue of classified operations between the front and the back.
// Depends on smdr_pkg.
module smdr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  smdr_pkg::op_t push_op,
  output logic          pop_valid,
  input  logic          pop_ready,
  output smdr_pkg::op_t pop_op
);
  import smdr_pkg::*;

  op_t              mem [QDepth];
  logic [QPtrW-1:0] wptr_r;
  logic [QPtrW-1:0] rptr_r;
  logic [QPtrW:0]   cnt_r;
  logic             push;
  logic             pop;

  assign push_ready = (cnt_r != (QPtrW+1)'(QDepth));
  assign pop_valid  = (cnt_r != '0);
  assign pop_op     = mem[rptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
    if (push) mem[wptr_r] <= push_op;
  end

endmodule

// ===== rtl/smdr_back.sv =====
// Back end: sequencer that multiplies over three 32x32 partial products or
// divides one quotient bit per cycle, then holds the result word. Depends on smdr_pkg.
module smdr_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          op_valid,
  output logic          op_ready,
  input  smdr_pkg::op_t op,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [63:0]   out_result,
  output logic          out_divide_by_zero
);
  import smdr_pkg::*;

  state_t           state_r, state_nxt;
  kind_t            kind_r;
  logic             wide_r, dbz_r, neg_q_r, neg_r_r;
  logic [DataW-1:0] a_r, b_r, acc_r, quo_r, rem_r;
  logic [CntW-1:0]  cnt_r;
  logic             out_valid_r;
  logic [DataW-1:0] out_result_r;
  logic             out_dbz_r;

  logic [HalfW-1:0]   mx, my;
  logic [DataW-1:0]   prod;
  logic [DataW:0]     trial;
  logic [DataW-1:0]   fin;
  logic [DataW-1:0]   fin_ext;
  logic               out_free;
  logic [DataW-1:0]   ma, mb;

  assign op_ready           = (state_r == ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_result         = out_result_r;
  assign out_divide_by_zero = out_dbz_r;
  assign out_free           = !out_valid_r || out_ready;

  assign ma = op.a[DataW-1] ? (~op.a + 1'b1) : op.a;
  assign mb = op.b[DataW-1] ? (~op.b + 1'b1) : op.b;

  // One shared multiplier: low*low, low*high, high*low.
  always_comb begin
    unique case (cnt_r[1:0])
      2'd0:    begin mx = a_r[HalfW-1:0];     my = b_r[HalfW-1:0];     end
      2'd1:    begin mx = a_r[HalfW-1:0];     my = b_r[DataW-1:HalfW]; end
      default: begin mx = a_r[DataW-1:HalfW]; my = b_r[HalfW-1:0];     end
    endcase
    prod  = DataW'(mx) * DataW'(my);
    trial = {rem_r, quo_r[DataW-1]} - {1'b0, b_r};
  end

  always_comb begin
    unique case (kind_r)
      OP_MUL:  fin = acc_r;
      OP_DIV:  fin = neg_q_r ? (~quo_r + 1'b1) : quo_r;
      OP_REM:  fin = neg_r_r ? (~rem_r + 1'b1) : rem_r;
      default: fin = '0;
    endcase
    fin_ext = wide_r ? fin : {{HalfW{fin[HalfW-1]}}, fin[HalfW-1:0]};
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (op_valid) begin
          unique case (op.kind)
            OP_MUL:         state_nxt = ST_MUL;
            OP_DIV, OP_REM: state_nxt = ST_DIV;
            default:        state_nxt = ST_FIN;
          endcase
        end
      end
      ST_MUL:  if (cnt_r == CntW'(2)) state_nxt = ST_FIN;
      ST_DIV:  if (cnt_r == CntW'(DataW - 1)) state_nxt = ST_FIN;
      default: if (out_free) state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_FIN && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (op_valid) begin
          kind_r  <= op.kind;
          wide_r  <= op.wide;
          dbz_r   <= op.dbz;
          neg_q_r <= op.a[DataW-1] ^ op.b[DataW-1];
          neg_r_r <= op.a[DataW-1];
          cnt_r   <= '0;
          acc_r   <= '0;
          rem_r   <= '0;
          if (op.kind == OP_MUL) begin
            a_r <= op.a;
            b_r <= op.b;
          end else begin
            quo_r <= ma;
            b_r   <= mb;
          end
        end
      end
      ST_MUL: begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == '0) acc_r <= prod;
        else acc_r <= acc_r + {prod[HalfW-1:0], {HalfW{1'b0}}};
      end
      ST_DIV: begin
        cnt_r <= cnt_r + 1'b1;
        if (!trial[DataW]) begin
          rem_r <= trial[DataW-1:0];
          quo_r <= {quo_r[DataW-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[DataW-2:0], quo_r[DataW-1]};
          quo_r <= {quo_r[DataW-2:0], 1'b0};
        end
      end
      default: begin
        if (out_free) begin
          out_result_r <= fin_ext;
          out_dbz_r    <= dbz_r;
        end
      end
    endcase
  end

endmodule

// ===== rtl/signed_int_mul_div_rem.sv =====
// Top level of the signed multiply/divide/remainder unit.
// Depends on smdr_pkg, smdr_front, smdr_queue and smdr_back.
//
// Input channel (in_valid/in_ready): mode (0 multiply, 1 divide, 2 remainder),
// wide (0: 32-bit, 1: 64-bit) and two signed operands. Output channel
// (out_valid/out_ready): one result word per input word, in order, with
// divide_by_zero set when a divide or remainder saw a zero divisor (result 0).
// In 32-bit mode operands use their low halves and the result is sign-extended.
//
// The front registers and classifies each word and pushes it into a
// four-entry queue, so it keeps taking a word per cycle until the queue fills.
// The back sequencer runs one word at a time and takes no new word until it
// is through with the last: it loads the word, then multiply sums the low*low,
// low*high and high*low partial products on a shared 32x32 multiplier, divide
// and remainder run a 64-bit subtract for each quotient bit, and zero divisor
// and unused mode go straight to the finish step, which registers the result.
// When the receiver stalls, the output word holds and the back waits in its
// finish step; the queue and front then fill and in_ready drops.
// Reset (rst_n low, synchronous) empties the front, the queue and the output.
module signed_int_mul_div_rem (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic        in_wide,
  input  logic [63:0] in_operand_a,
  input  logic [63:0] in_operand_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_result,
  output logic        out_divide_by_zero
);
  import smdr_pkg::*;

  // Front to queue, queue to back.
  logic fq_valid, fq_ready, qb_valid, qb_ready;
  op_t  fq_op, qb_op;

  smdr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_wide      (in_wide),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .op_valid     (fq_valid),
    .op_ready     (fq_ready),
    .op           (fq_op)
  );

  smdr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_op    (fq_op),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_op     (qb_op)
  );

  smdr_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .op_valid           (qb_valid),
    .op_ready           (qb_ready),
    .op                 (qb_op),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result         (out_result),
    .out_divide_by_zero (out_divide_by_zero)
  );

endmodule
